// ===== rtl/qrr_pkg.sv =====
// shared types and constants for the quadratic real root solver
// no dependencies
`default_nettype none

package qrr_pkg;

    // width of one root on the result side, signed fixed point
    localparam int ROOT_W = 34;
    // result tdata: status, larger root, smaller root, padded to bytes
    localparam int OUT_DATA_W = ((2 + 2 * ROOT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_NONE   = 2'd1,
        ST_LINEAR = 2'd2,
        ST_DEGEN  = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/qrr_disc.sv =====
// discriminant front end: input register, magnitude products, exact b*b-4ac
// depends on qrr_pkg
`default_nettype none

module qrr_disc
    import qrr_pkg::*;
#(
    parameter int CW = 16,
    parameter int FB = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic signed [CW-1:0]      i_coef_a,
    input  wire logic signed [CW-1:0]      i_coef_b,
    input  wire logic signed [CW-1:0]      i_coef_c,
    output logic                           o_valid,
    output logic [2*CW+1:0]                o_d,
    output logic signed [CW+FB+2:0]        o_base,
    output logic [CW+2:0]                  o_dmag,
    output logic                           o_den_neg,
    output t_status                        o_status
);

    localparam int GB  = FB + 2;
    localparam int DW  = 2 * CW + 2;
    localparam int MW  = CW + GB;
    localparam int DMW = CW + 3;

    // stage a: registered coefficients
    logic signed [CW-1:0] r_a, r_b, r_c;
    logic                 r_va;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= i_coef_a;
            r_b <= i_coef_b;
            r_c <= i_coef_c;
        end
    end

    // stage b: magnitudes and the two products
    logic [CW-1:0]   w_ua, w_ub, w_uc;
    logic [CW-1:0]   r_ua, r_ub, r_uc;
    logic [2*CW-1:0] r_bb, r_m;
    logic            r_a_zero, r_b_zero, r_opp, r_a_neg, r_b_neg, r_b_pos, r_c_pos;
    logic            r_vb;

    assign w_ua = r_a[CW-1] ? CW'(-r_a) : CW'(r_a);
    assign w_ub = r_b[CW-1] ? CW'(-r_b) : CW'(r_b);
    assign w_uc = r_c[CW-1] ? CW'(-r_c) : CW'(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua     <= w_ua;
            r_ub     <= w_ub;
            r_uc     <= w_uc;
            r_bb     <= (2*CW)'(w_ub) * (2*CW)'(w_ub);
            r_m      <= (2*CW)'(w_ua) * (2*CW)'(w_uc);
            r_a_zero <= (r_a == '0);
            r_b_zero <= (r_b == '0);
            r_opp    <= (r_c != '0) && (r_a[CW-1] != r_c[CW-1]);
            r_a_neg  <= r_a[CW-1];
            r_b_neg  <= r_b[CW-1];
            r_b_pos  <= !r_b[CW-1] && (r_b != '0);
            r_c_pos  <= !r_c[CW-1] && (r_c != '0);
        end
    end

    // stage c: discriminant, status, numerator base, denominator magnitude
    logic [DW-1:0] w_bb, w_m4, w_sum, w_diff, w_d;
    logic          w_less;
    t_status       w_status;
    logic [MW-1:0] w_bmag, w_cmag, w_mag;
    logic          w_neg;

    assign w_bb   = DW'(r_bb);
    assign w_m4   = {r_m, 2'b00};
    assign w_sum  = w_bb + w_m4;
    assign w_diff = w_bb - w_m4;
    assign w_less = w_m4 > w_bb;

    always_comb begin
        if (r_a_zero) begin
            w_status = r_b_zero ? ST_DEGEN : ST_LINEAR;
        end else if (!r_opp && w_less) begin
            w_status = ST_NONE;
        end else begin
            w_status = ST_TWO;
        end
    end

    assign w_d    = (w_status == ST_TWO) ? (r_opp ? w_sum : w_diff) : '0;
    assign w_bmag = MW'(r_ub) << GB;
    assign w_cmag = MW'(r_uc) << FB;
    assign w_mag  = r_a_zero ? w_cmag : w_bmag;
    assign w_neg  = r_a_zero ? r_c_pos : r_b_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d       <= w_d;
            o_base    <= w_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
            o_dmag    <= r_a_zero ? DMW'(r_ub) : {r_ua, 3'b000};
            o_den_neg <= r_a_zero ? r_b_neg : r_a_neg;
            o_status  <= w_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qrr_sqrt.sv =====
// pipelined digit-by-digit square root, one root bit per stage
// depends on qrr_pkg
`default_nettype none

module qrr_sqrt
    import qrr_pkg::*;
#(
    parameter int CW = 16,
    parameter int GB = 18,
    parameter int SW = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [2*CW+1:0]        i_d,
    input  wire logic [SW-1:0]          i_side,
    output logic                        o_valid,
    output logic [CW+GB:0]              o_root,
    output logic [SW-1:0]               o_side
);

    localparam int DW = 2 * CW + 2;
    localparam int SQ = CW + 1 + GB;
    localparam int RW = SQ + 2;

    logic [RW-1:0] r_rem  [SQ];
    logic [SQ-1:0] r_q    [SQ];
    logic [DW-1:0] r_d    [SQ];
    logic [SW-1:0] r_side [SQ];
    logic [SQ-1:0] r_v;

    for (genvar i = 0; i < SQ; i++) begin : g_step
        logic [RW-1:0] w_rem;
        logic [SQ-1:0] w_q;
        logic [DW-1:0] w_d;
        logic [SW-1:0] w_side;
        logic          w_v;
        logic [RW+1:0] w_rx, w_t, w_sub;
        logic          w_ge;

        if (i == 0) begin : g_first
            assign w_rem  = '0;
            assign w_q    = '0;
            assign w_d    = i_d;
            assign w_side = i_side;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[i-1];
            assign w_q    = r_q[i-1];
            assign w_d    = r_d[i-1];
            assign w_side = r_side[i-1];
            assign w_v    = r_v[i-1];
        end

        // bring down the next pair, try subtracting 4q+1
        assign w_rx  = {w_rem, w_d[DW-1 -: 2]};
        assign w_t   = (RW+2)'({w_q, 2'b01});
        assign w_ge  = w_rx >= w_t;
        assign w_sub = w_rx - w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= w_ge ? RW'(w_sub) : RW'(w_rx);
                r_q[i]    <= {w_q[SQ-2:0], w_ge};
                r_d[i]    <= {w_d[DW-3:0], 2'b00};
                r_side[i] <= w_side;
            end
        end
    end

    assign o_valid = r_v[SQ-1];
    assign o_root  = r_q[SQ-1];
    assign o_side  = r_side[SQ-1];

endmodule

`default_nettype wire

// ===== rtl/qrr_div.sv =====
// two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage
// depends on qrr_pkg
`default_nettype none

module qrr_div
    import qrr_pkg::*;
#(
    parameter int UW  = 38,
    parameter int DDW = 20,
    parameter int SW  = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [UW-1:0]      i_num0,
    input  wire logic [UW-1:0]      i_num1,
    input  wire logic [DDW-1:0]     i_den,
    input  wire logic [SW-1:0]      i_side,
    output logic                    o_valid,
    output logic [UW-1:0]           o_quo0,
    output logic [UW-1:0]           o_quo1,
    output logic [SW-1:0]           o_side
);

    logic [DDW-1:0] r_rem  [2][UW];
    logic [UW-1:0]  r_n    [2][UW];
    logic [UW-1:0]  r_q    [2][UW];
    logic [DDW-1:0] r_den  [UW];
    logic [SW-1:0]  r_side [UW];
    logic [UW-1:0]  r_v;

    for (genvar i = 0; i < UW; i++) begin : g_stage
        logic [DDW-1:0] w_den;
        logic [SW-1:0]  w_side;
        logic           w_v;

        if (i == 0) begin : g_first
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_den  = r_den[i-1];
            assign w_side = r_side[i-1];
            assign w_v    = r_v[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[i]  <= w_den;
                r_side[i] <= w_side;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DDW-1:0] w_rem;
            logic [UW-1:0]  w_n, w_q;
            logic [DDW:0]   w_rx, w_sub;
            logic           w_ge;

            if (i == 0) begin : g_first
                assign w_rem = '0;
                assign w_n   = (l == 0) ? i_num0 : i_num1;
                assign w_q   = '0;
            end else begin : g_next
                assign w_rem = r_rem[l][i-1];
                assign w_n   = r_n[l][i-1];
                assign w_q   = r_q[l][i-1];
            end

            assign w_rx  = {w_rem, w_n[UW-1]};
            assign w_ge  = w_rx >= (DDW+1)'(w_den);
            assign w_sub = w_rx - (DDW+1)'(w_den);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][i] <= w_ge ? DDW'(w_sub) : DDW'(w_rx);
                    r_n[l][i]   <= w_n << 1;
                    r_q[l][i]   <= {w_q[UW-2:0], w_ge};
                end
            end
        end
    end

    assign o_valid = r_v[UW-1];
    assign o_quo0  = r_q[0][UW-1];
    assign o_quo1  = r_q[1][UW-1];
    assign o_side  = r_side[UW-1];

endmodule

`default_nettype wire

// ===== rtl/quadratic_real_root_solver.sv =====
// real roots of a*x^2+b*x+c=0, roots in signed fixed point, round to nearest
// one beat per cycle while the skid register is empty; the whole pipeline stalls while it holds a beat
// square root and divider pipelines, one result bit per stage each
// synchronous active-low reset clears all valid bits; payload is not reset
// depends on qrr_pkg, qrr_disc, qrr_sqrt, qrr_div
`default_nettype none

module quadratic_real_root_solver
    import qrr_pkg::*;
#(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    // slave side: coefficient triples
    input  wire logic                                       i_s_tvalid,
    output logic                                            o_s_tready,
    // coef_a, coef_b, coef_c from bit 0 up, zero padded to bytes
    input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]          i_s_tdata,
    // master side: results
    output logic                                            o_m_tvalid,
    input  wire logic                                       i_m_tready,
    // root_status, larger_root, smaller_root from bit 0 up, zero padded
    output logic [OUT_DATA_W-1:0]                           o_m_tdata
);

    localparam int CW  = COEF_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int GB  = FB + 2;            // guard bits on the square root
    localparam int DW  = 2 * CW + 2;        // discriminant width
    localparam int SQ  = CW + 1 + GB;       // scaled square root width
    localparam int BW  = CW + GB + 1;       // signed numerator base
    localparam int DMW = CW + 3;            // |8a| or |b|
    localparam int NW  = CW + GB + 3;       // signed numerator base +/- root
    localparam int UW  = NW + 1;            // rounded dividend 2|n|+|d|
    localparam int DDW = DMW + 1;           // divisor 2|d|
    localparam int SSW = BW + DMW + 3;
    localparam int QS  = UW + 1;
    localparam int EW  = (QS > ROOT_W) ? QS : ROOT_W;
    localparam logic signed [EW-1:0] SAT_HI = EW'((65'(1) << (ROOT_W - 1)) - 65'(1));
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    // whole pipeline advances unless the skid register is holding a beat
    logic w_en;
    logic r_skd_v;
    assign w_en       = !r_skd_v;
    assign o_s_tready = w_en;

    // ---------------- discriminant ----------------
    logic                 w_dv;
    logic [DW-1:0]        w_d;
    logic signed [BW-1:0] w_base;
    logic [DMW-1:0]       w_dmag;
    logic                 w_den_neg;
    t_status              w_status;

    qrr_disc #(.CW(CW), .FB(FB)) u_disc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_tvalid),
        .i_coef_a  (i_s_tdata[CW-1:0]),
        .i_coef_b  (i_s_tdata[2*CW-1:CW]),
        .i_coef_c  (i_s_tdata[3*CW-1:2*CW]),
        .o_valid   (w_dv),
        .o_d       (w_d),
        .o_base    (w_base),
        .o_dmag    (w_dmag),
        .o_den_neg (w_den_neg),
        .o_status  (w_status)
    );

    // ---------------- square root ----------------
    // side band rides along: base, |d|, divisor sign, status
    logic           w_sv;
    logic [SQ-1:0]  w_s;
    logic [SSW-1:0] w_sside;

    qrr_sqrt #(.CW(CW), .GB(GB), .SW(SSW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv),
        .i_d     (w_d),
        .i_side  ({w_base, w_dmag, w_den_neg, w_status}),
        .o_valid (w_sv),
        .o_root  (w_s),
        .o_side  (w_sside)
    );

    // ---------------- numerators ----------------
    // k = round((base +/- s) / d); linear case has s forced to zero
    logic signed [BW-1:0] w_sbase;
    logic [DMW-1:0]       w_sdmag;
    logic                 w_sden_neg;
    t_status              w_sstatus;
    logic signed [NW-1:0] w_n0, w_n1, w_sx;
    logic [NW-2:0]        w_m0, w_m1;

    assign w_sbase    = w_sside[SSW-1 -: BW];
    assign w_sdmag    = w_sside[DMW+2:3];
    assign w_sden_neg = w_sside[2];
    assign w_sstatus  = t_status'(w_sside[1:0]);
    assign w_sx       = (w_sstatus == ST_TWO) ? $signed(NW'(w_s)) : '0;
    assign w_n0       = NW'(w_sbase) + w_sx;
    assign w_n1       = NW'(w_sbase) - w_sx;
    assign w_m0       = w_n0[NW-1] ? (NW-1)'(-w_n0) : (NW-1)'(w_n0);
    assign w_m1       = w_n1[NW-1] ? (NW-1)'(-w_n1) : (NW-1)'(w_n1);

    logic            r_nv;
    logic [UW-1:0]   r_un0, r_un1;
    logic [DDW-1:0]  r_dd;
    logic [4:0]      r_nside;   // neg1, neg0, divisor sign, status

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (w_en) begin
            r_nv <= w_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_un0   <= UW'({w_m0, 1'b0}) + UW'(w_sdmag);
            r_un1   <= UW'({w_m1, 1'b0}) + UW'(w_sdmag);
            r_dd    <= {w_sdmag, 1'b0};
            r_nside <= {w_n1[NW-1] ^ w_sden_neg, w_n0[NW-1] ^ w_sden_neg,
                        w_sden_neg, w_sstatus};
        end
    end

    // ---------------- division ----------------
    logic          w_qv;
    logic [UW-1:0] w_q0, w_q1;
    logic [4:0]    w_qside;

    qrr_div #(.UW(UW), .DDW(DDW), .SW(5)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_nv),
        .i_num0  (r_un0),
        .i_num1  (r_un1),
        .i_den   (r_dd),
        .i_side  (r_nside),
        .o_valid (w_qv),
        .o_quo0  (w_q0),
        .o_quo1  (w_q1),
        .o_side  (w_qside)
    );

    // ---------------- sign, saturate, order ----------------
    logic signed [EW-1:0] w_v0, w_v1;
    logic [ROOT_W-1:0]    w_r0, w_r1, w_large, w_small;
    t_status              w_qstatus;
    logic                 w_zero;

    assign w_v0 = w_qside[3] ? -EW'($signed({1'b0, w_q0})) : EW'($signed({1'b0, w_q0}));
    assign w_v1 = w_qside[4] ? -EW'($signed({1'b0, w_q1})) : EW'($signed({1'b0, w_q1}));
    assign w_r0 = (w_v0 > SAT_HI) ? ROOT_W'(SAT_HI)
                : (w_v0 < SAT_LO) ? ROOT_W'(SAT_LO) : ROOT_W'(w_v0);
    assign w_r1 = (w_v1 > SAT_HI) ? ROOT_W'(SAT_HI)
                : (w_v1 < SAT_LO) ? ROOT_W'(SAT_LO) : ROOT_W'(w_v1);
    assign w_qstatus = t_status'(w_qside[1:0]);
    assign w_zero    = (w_qstatus == ST_NONE) || (w_qstatus == ST_DEGEN);
    // base+s over a negative divisor gives the smaller root
    assign w_large   = w_zero ? '0 : (w_qside[2] ? w_r1 : w_r0);
    assign w_small   = w_zero ? '0 : (w_qside[2] ? w_r0 : w_r1);

    logic                  r_rv;
    logic [OUT_DATA_W-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (w_en) begin
            r_rv <= w_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= OUT_DATA_W'({w_small, w_large, w_qstatus});
        end
    end

    // ---------------- output register with skid ----------------
    logic                  r_out_v;
    logic [OUT_DATA_W-1:0] r_out, r_skd;
    logic                  w_fire;

    assign w_fire = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (w_fire) begin
                r_skd_v <= 1'b0;
            end
        end else if (!r_out_v || w_fire) begin
            r_out_v <= r_rv;
        end else if (r_rv) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_v) begin
            if (w_fire) begin
                r_out <= r_skd;
            end
        end else if (!r_out_v || w_fire) begin
            r_out <= r_res;
        end else begin
            r_skd <= r_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

// ===== tb/sv/quadratic_real_root_solver_tb.sv =====
// self-checking testbench for the quadratic real root solver
// streams coefficient triples in, checks every result against a built-in predictor
// depends on qrr_pkg and quadratic_real_root_solver
`default_nettype none

module quadratic_real_root_solver_tb;
    import qrr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW       = 16;
    localparam int FB       = 16;
    localparam int GB       = FB + 2;       // guard bits inside the square root
    localparam int IN_W     = ((3 * CW + 7) / 8) * 8;
    localparam int LATENCY  = 2 * CW + 2 * FB + 15;
    localparam int STALL_MAX = 17;
    localparam int WATCHDOG = 40 * (LATENCY + STALL_MAX);
    localparam int CALM_TAIL = 60;           // last beats go without idling
    localparam longint ROOT_MAX = (64'sd1 <<< (ROOT_W - 1)) - 1;
    localparam longint ROOT_MIN = -ROOT_MAX - 1;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
    } t_coefs;

    typedef struct packed {
        t_status                  status;
        logic signed [ROOT_W-1:0] larger;
        logic signed [ROOT_W-1:0] smaller;
    } t_roots;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    t_coefs coef_queue[$];    // triples waiting to be sent
    t_roots roots_queue[$];   // predicted results in flight
    int     failures = 0;
    int     quiet_cycles = 0;
    int     send_idle = 0;
    int     recv_idle = 0;

    quadratic_real_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // nearest integer of num/den, ties away from zero
    function automatic longint div_nearest(longint num, longint den);
        longint un;
        longint ud;
        longint q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (2 * un + ud) / (2 * ud);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic signed [ROOT_W-1:0] clamp_root(longint v);
        longint r;
        r = (v > ROOT_MAX) ? ROOT_MAX : ((v < ROOT_MIN) ? ROOT_MIN : v);
        return r[ROOT_W-1:0];
    endfunction

    // floor of the square root, bit by bit from the top
    function automatic logic [39:0] isqrt80(logic [79:0] v);
        logic [39:0] q;
        logic [39:0] trial;
        q = '0;
        for (int p = 39; p >= 0; p--) begin
            trial = q | (40'd1 << p);
            if ({40'd0, trial} * {40'd0, trial} <= v)
                q = trial;
        end
        return q;
    endfunction

    function automatic t_roots solve_roots(t_coefs t);
        t_roots r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint s;
        longint nb;
        longint k1;
        longint k2;
        a = t.a;
        b = t.b;
        c = t.c;
        r = '{status: ST_TWO, larger: '0, smaller: '0};
        if (a == 0) begin
            if (b == 0) begin
                r.status = ST_DEGEN;
            end else begin
                r.status  = ST_LINEAR;
                r.larger  = clamp_root(div_nearest(-c * (64'sd1 <<< FB), b));
                r.smaller = r.larger;
            end
        end else begin
            disc = b * b - 4 * a * c;
            if (disc < 0) begin
                r.status = ST_NONE;
            end else begin
                // sqrt(D) * 2^G == sqrt(D * 2^(2G)), floored
                s  = longint'(isqrt80(80'(disc) << (2 * GB)));
                nb = -b * (64'sd1 <<< GB);
                k1 = div_nearest(nb + s, 8 * a);
                k2 = div_nearest(nb - s, 8 * a);
                r.larger  = clamp_root(k1 > k2 ? k1 : k2);
                r.smaller = clamp_root(k1 > k2 ? k2 : k1);
            end
        end
        return r;
    endfunction

    function automatic t_coefs triple(int a, int b, int c);
        t_coefs t;
        t.a = a[CW-1:0];
        t.b = b[CW-1:0];
        t.c = c[CW-1:0];
        return t;
    endfunction

    function automatic int rand_coef();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // driver: holds a beat until it is taken, idles in random bursts
    always @(posedge i_clk) begin
        logic   load;
        t_coefs t;
        if (i_rst_n) begin
            load = !i_s_tvalid || o_s_tready;
            if (load) begin
                if (send_idle > 0) begin
                    send_idle <= send_idle - 1;
                    i_s_tvalid <= 1'b0;
                end else if (coef_queue.size() > CALM_TAIL && $urandom_range(7) == 0) begin
                    send_idle <= $urandom_range(STALL_MAX - 1);
                    i_s_tvalid <= 1'b0;
                end else if (coef_queue.size() > 0) begin
                    t = coef_queue.pop_front();
                    i_s_tdata  <= IN_W'({t.c, t.b, t.a});
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure in random bursts, none in the tail
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (recv_idle > 0) begin
                recv_idle  <= recv_idle - 1;
                i_m_tready <= 1'b0;
            end else if (coef_queue.size() > CALM_TAIL && $urandom_range(7) == 0) begin
                recv_idle  <= $urandom_range(STALL_MAX - 1);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // monitor: predicts on each input beat, checks each output beat
    always @(posedge i_clk) begin
        t_roots want;
        t_roots got;
        logic   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                // struct holds a in its top bits, tdata holds a in its low bits
                roots_queue.push_back(solve_roots(t_coefs'({i_s_tdata[CW-1:0],
                    i_s_tdata[2*CW-1:CW], i_s_tdata[3*CW-1:2*CW]})));
                moved = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                // tdata: status, larger, smaller from bit 0 up
                got.status  = t_status'(o_m_tdata[1:0]);
                got.larger  = o_m_tdata[2 +: ROOT_W];
                got.smaller = o_m_tdata[2 + ROOT_W +: ROOT_W];
                if (roots_queue.size() == 0) begin
                    $error("result beat with no expectation: status %0d", got.status);
                    failures++;
                end else begin
                    want = roots_queue.pop_front();
                    if (got.status !== want.status) begin
                        $error("root_status expected %0d actual %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.larger !== want.larger) begin
                        $error("larger_root expected %0d actual %0d", want.larger, got.larger);
                        failures++;
                    end
                    if (got.smaller !== want.smaller) begin
                        $error("smaller_root expected %0d actual %0d",
                               want.smaller, got.smaller);
                        failures++;
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int s;
        // extremes of every field
        coef_queue.push_back(triple(32767, 32767, 32767));
        coef_queue.push_back(triple(-32768, -32768, -32768));
        coef_queue.push_back(triple(-32768, 32767, 32767));
        coef_queue.push_back(triple(32767, -32768, -32768));
        coef_queue.push_back(triple(1, -32768, -32768));
        coef_queue.push_back(triple(-1, 32767, 0));
        coef_queue.push_back(triple(32767, 0, -32768));
        // degenerate a = b = 0
        coef_queue.push_back(triple(0, 0, 0));
        coef_queue.push_back(triple(0, 0, -32768));
        // linear
        coef_queue.push_back(triple(0, 1, -32768));
        coef_queue.push_back(triple(0, -32768, 32767));
        coef_queue.push_back(triple(0, 3, 1));
        coef_queue.push_back(triple(0, 32767, -1));
        // no real roots
        coef_queue.push_back(triple(1, 0, 1));
        coef_queue.push_back(triple(32767, 1, 32767));
        // double roots
        coef_queue.push_back(triple(1, 2, 1));
        coef_queue.push_back(triple(-4, 12, -9));
        coef_queue.push_back(triple(16384, -32768, 16384));
        // two distinct roots, one with a zero constant term
        coef_queue.push_back(triple(2, -3, 0));
        coef_queue.push_back(triple(1, 0, -2));
        // random part: full range, small values, linear, double roots, zero constant term
        for (int n = 0; n < 450; n++) begin
            case ($urandom_range(5))
                0, 1: coef_queue.push_back(triple(rand_coef(), rand_coef(), rand_coef()));
                2: coef_queue.push_back(triple(int'($urandom_range(32)) - 16,
                        int'($urandom_range(64)) - 32, int'($urandom_range(32)) - 16));
                3: coef_queue.push_back(triple(0, rand_coef(), rand_coef()));
                4: begin
                    r = int'($urandom_range(180)) - 90;
                    s = int'($urandom_range(180)) - 90;
                    if (r == 0) r = 1;
                    coef_queue.push_back(triple(r * r, 2 * r * s, s * s));
                end
                default: coef_queue.push_back(triple(rand_coef(), rand_coef(), 0));
            endcase
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (coef_queue.size() == 0 && !i_s_tvalid);
        wait (roots_queue.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (roots_queue.size() != 0) begin
            $error("%0d expected results never arrived", roots_queue.size());
            failures++;
        end
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
